>>> rtl/core/spi_eeprom_access_sequencer_unit_defines.svh
// Assertion macros for the SPI EEPROM access sequencer.
`ifndef SPI_EEPROM_ACCESS_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_EEPROM_ACCESS_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk_i, held off during reset
`define SEAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SEAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEAS_ASSERT_IMP(lbl, ante, cons, msg)
`define SEAS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/seas_pkg.sv
// Types, codes and helpers shared by the SPI EEPROM access sequencer.
`default_nettype none
package seas_pkg;

  // request codes
  localparam logic [1:0] ReqRead   = 2'd0;
  localparam logic [1:0] ReqWrite  = 2'd1;
  localparam logic [1:0] ReqRxByte = 2'd2;

  // EEPROM opcodes
  localparam logic [7:0] CmdWrite  = 8'h02;
  localparam logic [7:0] CmdRdsr   = 8'h05;
  localparam logic [7:0] CmdRead   = 8'h03;
  localparam logic [7:0] CmdWren   = 8'h06;
  localparam logic [7:0] DummyByte = 8'h00;

  localparam int unsigned AddrW = 9;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] address;
    logic [7:0]       write_value;
    logic [7:0]       rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       read_valid;
    logic [7:0] read_data;
    logic       write_done;
    logic       rejected;
  } out_item_t;

  // result batch handed from the step logic to the output buffer
  typedef struct packed {
    logic                load;
    logic [1:0]          num;
    out_item_t [2:0]     item;
  } res_load_t;

  function automatic out_item_t tx_item(logic [7:0] b, logic last);
    out_item_t r;
    r = '0;
    r.tx_valid   = 1'b1;
    r.tx_byte    = b;
    r.frame_last = last;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/seas_if.sv
// Valid/ready channel interfaces for request and result items.
`default_nettype none
interface seas_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [8:0] address;
  logic [7:0] write_value;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, address, write_value, rx_byte, input ready);
  modport sink   (input valid, req_type, address, write_value, rx_byte, output ready);
endinterface

interface seas_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       frame_last;
  logic       read_valid;
  logic [7:0] read_data;
  logic       write_done;
  logic       rejected;

  modport source (output valid, tx_valid, tx_byte, frame_last, read_valid, read_data,
                  write_done, rejected, input ready);
  modport sink   (input valid, tx_valid, tx_byte, frame_last, read_valid, read_data,
                  write_done, rejected, output ready);
endinterface
`default_nettype wire

>>> rtl/core/seas_step.sv
// Input register, access phase state and per-item result generation.
`default_nettype none
module seas_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire seas_pkg::in_item_t  in_item_i,
  output logic                     in_ready_o,
  input  wire logic                load_ok_i,
  output seas_pkg::res_load_t      res_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhPollA = 3'd1,
    PhPollB = 3'd2,
    PhWren  = 3'd3,
    PhWrite = 3'd4,
    PhRead  = 3'd5
  } phase_e;

  seas_pkg::in_item_t in_q;
  logic               in_vld_q;
  phase_e             phase_q, phase_d;
  logic               op_wr_q, op_wr_d;
  logic [8:0]         addr_q, addr_d;
  logic [7:0]         val_q, val_d;
  logic [1:0]         br_q, br_d;
  logic [1:0]         cnt;
  logic [7:0]         a8_bits;
  logic               xfer;

  assign xfer       = in_vld_q & load_ok_i;
  assign in_ready_o = ~in_vld_q | load_ok_i;
  assign cnt        = br_q + 2'd1;
  assign a8_bits    = {4'b0000, addr_q[8], 3'b000};

  always_comb begin
    phase_d = phase_q;
    op_wr_d = op_wr_q;
    addr_d  = addr_q;
    val_d   = val_q;
    br_d    = br_q;
    res_o      = '0;
    res_o.load = xfer;
    if (in_q.req_type == seas_pkg::ReqRead || in_q.req_type == seas_pkg::ReqWrite) begin
      if (phase_q != PhIdle) begin
        res_o.num              = 2'd1;
        res_o.item[0].rejected = 1'b1;
      end else begin
        op_wr_d = in_q.req_type[0];
        addr_d  = in_q.address;
        val_d   = in_q.write_value;
        br_d    = 2'd0;
        phase_d = PhPollA;
        res_o.num     = 2'd2;
        res_o.item[0] = seas_pkg::tx_item(seas_pkg::CmdRdsr, 1'b0);
        res_o.item[1] = seas_pkg::tx_item(seas_pkg::DummyByte, 1'b1);
      end
    end else if (in_q.req_type == seas_pkg::ReqRxByte && phase_q != PhIdle) begin
      br_d = cnt;
      case (phase_q)
        PhPollA, PhPollB: begin
          if (cnt >= 2'd2) begin
            br_d = 2'd0;
            if (in_q.rx_byte[0] || (phase_q == PhPollA && op_wr_q)) begin
              // busy status, or first of the two write polls: poll again
              if (!in_q.rx_byte[0]) phase_d = PhPollB;
              res_o.num     = 2'd2;
              res_o.item[0] = seas_pkg::tx_item(seas_pkg::CmdRdsr, 1'b0);
              res_o.item[1] = seas_pkg::tx_item(seas_pkg::DummyByte, 1'b1);
            end else if (phase_q == PhPollA) begin
              phase_d = PhRead;
              res_o.num     = 2'd3;
              res_o.item[0] = seas_pkg::tx_item(seas_pkg::CmdRead | a8_bits, 1'b0);
              res_o.item[1] = seas_pkg::tx_item(addr_q[7:0], 1'b0);
              res_o.item[2] = seas_pkg::tx_item(seas_pkg::DummyByte, 1'b1);
            end else begin
              phase_d = PhWren;
              res_o.num     = 2'd1;
              res_o.item[0] = seas_pkg::tx_item(seas_pkg::CmdWren, 1'b1);
            end
          end
        end
        PhWren: begin
          br_d    = 2'd0;
          phase_d = PhWrite;
          res_o.num     = 2'd3;
          res_o.item[0] = seas_pkg::tx_item(seas_pkg::CmdWrite | a8_bits, 1'b0);
          res_o.item[1] = seas_pkg::tx_item(addr_q[7:0], 1'b0);
          res_o.item[2] = seas_pkg::tx_item(val_q, 1'b1);
        end
        PhWrite: begin
          if (cnt == 2'd3) begin
            br_d    = 2'd0;
            phase_d = PhIdle;
            res_o.num                = 2'd1;
            res_o.item[0].write_done = 1'b1;
          end
        end
        PhRead: begin
          if (cnt == 2'd3) begin
            br_d    = 2'd0;
            phase_d = PhIdle;
            res_o.num                = 2'd1;
            res_o.item[0].read_valid = 1'b1;
            res_o.item[0].read_data  = in_q.rx_byte;
          end
        end
        default: begin
          br_d    = 2'd0;
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PhIdle;
      op_wr_q  <= 1'b0;
      addr_q   <= '0;
      val_q    <= '0;
      br_q     <= '0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (xfer) begin
        phase_q <= phase_d;
        op_wr_q <= op_wr_d;
        addr_q  <= addr_d;
        val_q   <= val_d;
        br_q    <= br_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
  end

endmodule
`default_nettype wire

>>> rtl/core/seas_obuf.sv
// Three-slot result buffer, one result item per cycle if out_ready_i.
`default_nettype none
module seas_obuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire seas_pkg::res_load_t res_i,
  output logic                     load_ok_o,
  output logic                     out_valid_o,
  output seas_pkg::out_item_t      out_item_o,
  input  wire logic                out_ready_i
);

  seas_pkg::out_item_t [2:0] slot_q;
  logic [1:0]                rem_q;
  logic [1:0]                idx_q;
  logic                      pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;
  // free when empty or once the last pending result leaves this cycle
  assign load_ok_o   = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
  assign out_item_o  = slot_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (res_i.load && load_ok_o) begin
      rem_q <= res_i.num;
      idx_q <= 2'd0;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load && load_ok_o) slot_q <= res_i.item;
  end

endmodule
`default_nettype wire

>>> rtl/core/spi_eeprom_access_sequencer_unit.sv
// Top level of the SPI EEPROM access sequencer.
//
// Usage: in_i carries requests (read, write) and bytes received from the SPI
// shifter; out_o carries result items: bytes to send with a frame-end flag,
// completed reads, write completion and rejections. Each accepted item gives
// zero to three result items, in order, one per cycle on out_o while it is ready.
// Path: an accepted item is held in the input register and decoded from it;
// its results are loaded into the result buffer once that is free, the first
// result is presented after the load, the rest on following cycles.
// Throughput: one item per cycle when it yields at most one result and out_o is
// ready; else the next item waits out its results (single-output result buffer).
// Stall: while out_o is held, the input register still takes one item; after
// that in_i.ready drops until the buffer drains. Nothing is dropped.
// Reset: asynchronous, active low; the sequencer returns to idle with no
// access held and the buffers empty.
// A request that arrives mid-access gives one item with rejected set; a
// received byte while idle gives nothing.
`default_nettype none
`include "spi_eeprom_access_sequencer_unit_defines.svh"
module spi_eeprom_access_sequencer_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  seas_in_if.sink     in_i,
  seas_out_if.source  out_o
);

  seas_pkg::in_item_t  in_item;
  seas_pkg::res_load_t res;
  seas_pkg::out_item_t out_item;
  logic                load_ok;
  logic                in_ready;
  logic                out_valid;

  assign in_item.req_type    = in_i.req_type;
  assign in_item.address     = in_i.address;
  assign in_item.write_value = in_i.write_value;
  assign in_item.rx_byte     = in_i.rx_byte;
  assign in_i.ready          = in_ready;

  // phase tracking and result decode
  seas_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_ready),
    .load_ok_i  (load_ok),
    .res_o      (res)
  );

  // result items leave one per cycle while out_o is ready
  seas_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid      = out_valid;
  assign out_o.tx_valid   = out_item.tx_valid;
  assign out_o.tx_byte    = out_item.tx_byte;
  assign out_o.frame_last = out_item.frame_last;
  assign out_o.read_valid = out_item.read_valid;
  assign out_o.read_data  = out_item.read_data;
  assign out_o.write_done = out_item.write_done;
  assign out_o.rejected   = out_item.rejected;

  // input only backs up behind pending results
  `SEAS_ASSERT_IMP(a_stall_needs_output, !in_ready, out_valid, "input stalled with no result pending")
  // a rejection carries nothing else
  `SEAS_ASSERT_IMP(a_reject_clean, out_valid && out_item.rejected, !out_item.tx_valid && !out_item.read_valid && !out_item.write_done, "rejected item carries other flags")
  // frame end only on a sent byte
  `SEAS_ASSERT_IMP(a_last_on_tx, out_valid && out_item.frame_last, out_item.tx_valid, "frame end without byte")
  // a loaded batch is presented on the next cycle when nonempty
  `SEAS_ASSERT_NXT(a_batch_shown, res.load && load_ok && res.num != 2'd0, out_valid, "loaded results not presented")

endmodule
`default_nettype wire
